### rtl/core/direct_mapped_cache_read_defines.svh
// ----------------------------------------------------------------------------
// Direct-mapped cache read: assertion macros
// Concurrent assertion wrappers, empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_READ_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_READ_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define DMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen outside reset.
`define DMC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `DMC_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define DMC_ASSERT(lbl, clk, rstn, prop, msg)
`define DMC_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

### rtl/core/dmc_pkg.sv
// ----------------------------------------------------------------------------
// Direct-mapped cache read: package
// Field widths, register indexes, reset values, state and payload types.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned DATA_W      = 8;
  localparam int unsigned NUM_LINES   = 8;
  localparam int unsigned LINE_BYTES  = 16;
  localparam int unsigned OFF_W       = $clog2(LINE_BYTES);
  localparam int unsigned IDX_W       = $clog2(NUM_LINES);
  localparam int unsigned BLK_W       = ADDR_W - OFF_W;
  localparam int unsigned TAG_W       = BLK_W - IDX_W;
  localparam int unsigned LINE_MEM_AW = IDX_W + OFF_W;
  localparam int unsigned FILL_CNT_W  = $clog2(LINE_BYTES + 1);
  localparam int unsigned TOT_W       = 32;
  localparam int unsigned COST_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam int unsigned REQ_W       = 24;
  localparam int unsigned REQ_USED_W  = ADDR_W + DATA_W;
  localparam int unsigned RSP_W       = 128;
  localparam int unsigned RSP_USED_W  = DATA_W + TAG_W + IDX_W + OFF_W + BLK_W + 3 * TOT_W;

  localparam logic [FILL_CNT_W-1:0] FILL_FIRST = '0;
  localparam logic [FILL_CNT_W-1:0] FILL_ONE   = FILL_CNT_W'(1);
  localparam logic [FILL_CNT_W-1:0] FILL_DONE  = FILL_CNT_W'(LINE_BYTES);

  localparam logic [TOT_W-1:0] TOT_ONE = TOT_W'(1);

  localparam logic [CFG_IDX_W-1:0] CFG_HIT_COST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_COST = 1'd1;

  localparam logic [COST_W-1:0] HIT_COST_RST  = 8'd1;
  localparam logic [COST_W-1:0] MISS_COST_RST = 8'd20;

  typedef enum logic {
    FUNC_STORE = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] addr;
  } req_data_t;

  typedef struct packed {
    logic [TOT_W-1:0]  reads_total;
    logic [TOT_W-1:0]  misses_total;
    logic [TOT_W-1:0]  time_total;
    logic [BLK_W-1:0]  block_number;
    logic [OFF_W-1:0]  word_offset;
    logic [IDX_W-1:0]  line_index;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] rdata;
  } rsp_data_t;

endpackage

### rtl/core/direct_mapped_cache_read.sv
// ----------------------------------------------------------------------------
// Direct-mapped cache read
// A read-only cache of 8 lines of 16 bytes in front of a byte-wide backing
// RAM of RAM_BYTES bytes (a power of two). A request with tuser 0 stores one
// byte into the backing RAM; with tuser 1 it reads one byte through the
// cache and reports the address decoding, the saturating elapsed time and
// the miss and read counts. A store or a hit goes from IDLE through RESP
// into the output register; a miss first passes FILL, where the line is
// refilled one byte per cycle through the single read port of the backing
// RAM. One request is in flight at a time; a new one is taken while the
// previous result still waits in the output register. No reset sweep: the
// block accepts requests from the first cycle after reset. Reading backing
// RAM bytes never stored gives undefined data.
// ----------------------------------------------------------------------------
`include "direct_mapped_cache_read_defines.svh"

module direct_mapped_cache_read #(
  parameter int unsigned RAM_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dmc_pkg::COST_W-1:0]      cfg_wdata_i,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dmc_pkg::REQ_W-1:0]       s_axis_tdata,  // addr, wdata
  input  logic                            s_axis_tuser,  // func
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rdata, tag, line_index, word_offset, block_number, time_total,
  // misses_total, reads_total
  output logic [dmc_pkg::RSP_W-1:0]       m_axis_tdata,
  output logic                            m_axis_tuser   // hit
);

  localparam int unsigned RAM_AW = $clog2(RAM_BYTES);

  dmc_pkg::state_e state_q, state_d;

  dmc_pkg::req_data_t in_req;
  logic [dmc_pkg::OFF_W-1:0] in_word;
  logic [dmc_pkg::IDX_W-1:0] in_line;
  logic [dmc_pkg::TAG_W-1:0] in_tag;
  logic                      in_hit;
  logic                      accept;
  logic                      in_read;

  logic                      line_valid_q [dmc_pkg::NUM_LINES];
  logic [dmc_pkg::TAG_W-1:0] line_tag_q   [dmc_pkg::NUM_LINES];

  logic [dmc_pkg::COST_W-1:0] hit_cost_q, miss_cost_q;

  dmc_pkg::func_e             func_q;
  logic [dmc_pkg::ADDR_W-1:0] addr_q;
  logic                       hit_q;
  logic [dmc_pkg::BLK_W-1:0]  addr_blk;
  logic [dmc_pkg::OFF_W-1:0]  addr_word;
  logic [dmc_pkg::IDX_W-1:0]  addr_line;
  logic [dmc_pkg::TAG_W-1:0]  addr_tag;

  logic [dmc_pkg::FILL_CNT_W-1:0] fill_cnt_q, fill_prev_cnt;
  logic [dmc_pkg::OFF_W-1:0]      fill_prev_off;
  logic                           fill_rd, fill_wr;
  logic [dmc_pkg::DATA_W-1:0]     miss_byte_q;

  logic                       bram_we;
  logic [RAM_AW-1:0]          bram_waddr, bram_raddr;
  logic [dmc_pkg::DATA_W-1:0] bram_rdata;

  logic                            lmem_re;
  logic [dmc_pkg::LINE_MEM_AW-1:0] lmem_waddr, lmem_raddr;
  logic [dmc_pkg::DATA_W-1:0]      lmem_rdata;

  logic [dmc_pkg::TOT_W-1:0] time_q, misses_q, reads_q;
  logic [dmc_pkg::TOT_W-1:0] time_d, misses_d, reads_d;
  logic [dmc_pkg::TOT_W:0]   time_sum;
  logic [dmc_pkg::COST_W-1:0] cost;
  logic                       is_read;
  logic                       rsp_load;
  dmc_pkg::rsp_data_t         rsp_d, rsp_q;
  logic                       out_valid_q, out_hit_q;

  function automatic logic [dmc_pkg::TOT_W-1:0] sat_inc(input logic [dmc_pkg::TOT_W-1:0] v);
    return (&v) ? v : v + dmc_pkg::TOT_ONE;
  endfunction

  // --------------------------------------------------------------------------
  // Request decode and tag lookup
  // --------------------------------------------------------------------------
  assign in_req  = dmc_pkg::req_data_t'(s_axis_tdata[dmc_pkg::REQ_USED_W-1:0]);
  assign in_word = in_req.addr[dmc_pkg::OFF_W-1:0];
  assign in_line = in_req.addr[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
  assign in_tag  = in_req.addr[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
  assign in_hit  = line_valid_q[in_line] && (line_tag_q[in_line] == in_tag);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign in_read = (dmc_pkg::func_e'(s_axis_tuser) == dmc_pkg::FUNC_READ);

  assign addr_blk  = addr_q[dmc_pkg::ADDR_W-1:dmc_pkg::OFF_W];
  assign addr_word = addr_q[dmc_pkg::OFF_W-1:0];
  assign addr_line = addr_q[dmc_pkg::OFF_W +: dmc_pkg::IDX_W];
  assign addr_tag  = addr_q[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cost_q  <= dmc_pkg::HIT_COST_RST;
      miss_cost_q <= dmc_pkg::MISS_COST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmc_pkg::CFG_HIT_COST:  hit_cost_q  <= cfg_wdata_i;
        dmc_pkg::CFG_MISS_COST: miss_cost_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Line tags and valid bits: claim the line as soon as a miss is taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dmc_pkg::NUM_LINES; i++) begin
        line_valid_q[i] <= 1'b0;
        line_tag_q[i]   <= '0;
      end
    end else if (accept && in_read && !in_hit) begin
      line_valid_q[in_line] <= 1'b1;
      line_tag_q[in_line]   <= in_tag;
    end
  end

  // --------------------------------------------------------------------------
  // Request registers and refill counter
  // --------------------------------------------------------------------------
  assign fill_rd       = (state_q == dmc_pkg::ST_FILL) && (fill_cnt_q != dmc_pkg::FILL_DONE);
  assign fill_wr       = (state_q == dmc_pkg::ST_FILL) && (fill_cnt_q != dmc_pkg::FILL_FIRST);
  assign fill_prev_cnt = fill_cnt_q - dmc_pkg::FILL_ONE;
  assign fill_prev_off = fill_prev_cnt[dmc_pkg::OFF_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q     <= dmc_pkg::FUNC_STORE;
      hit_q      <= 1'b0;
      fill_cnt_q <= dmc_pkg::FILL_FIRST;
    end else if (accept) begin
      func_q     <= dmc_pkg::func_e'(s_axis_tuser);
      hit_q      <= in_read && in_hit;
      fill_cnt_q <= dmc_pkg::FILL_FIRST;
    end else if (state_q == dmc_pkg::ST_FILL) begin
      fill_cnt_q <= fill_cnt_q + dmc_pkg::FILL_ONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= in_req.addr;
    end
    // keep the requested byte as it passes into the line
    if (fill_wr && (fill_prev_off == addr_word)) begin
      miss_byte_q <= bram_rdata;
    end
  end

  // --------------------------------------------------------------------------
  // Memories
  // --------------------------------------------------------------------------
  assign bram_we    = accept && !in_read;
  assign bram_waddr = RAM_AW'(in_req.addr);
  assign bram_raddr = RAM_AW'({addr_blk, fill_cnt_q[dmc_pkg::OFF_W-1:0]});

  dmc_ram #(
    .WIDTH (dmc_pkg::DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_backing_ram (
    .clk_i   (clk_i),
    .we_i    (bram_we),
    .waddr_i (bram_waddr),
    .wdata_i (in_req.wdata),
    .re_i    (fill_rd),
    .raddr_i (bram_raddr),
    .rdata_o (bram_rdata)
  );

  assign lmem_re    = accept && in_read && in_hit;
  assign lmem_raddr = {in_line, in_word};
  assign lmem_waddr = {addr_line, fill_prev_off};

  dmc_ram #(
    .WIDTH (dmc_pkg::DATA_W),
    .DEPTH (dmc_pkg::NUM_LINES * dmc_pkg::LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (fill_wr),
    .waddr_i (lmem_waddr),
    .wdata_i (bram_rdata),
    .re_i    (lmem_re),
    .raddr_i (lmem_raddr),
    .rdata_o (lmem_rdata)
  );

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    rsp_load      = 1'b0;
    unique case (state_q)
      dmc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          state_d = (in_read && !in_hit) ? dmc_pkg::ST_FILL : dmc_pkg::ST_RESP;
        end
      end
      dmc_pkg::ST_FILL: begin
        if (fill_cnt_q == dmc_pkg::FILL_DONE) begin
          state_d = dmc_pkg::ST_RESP;
        end
      end
      dmc_pkg::ST_RESP: begin
        // wait for the output register to free up
        if (!out_valid_q || m_axis_tready) begin
          rsp_load = 1'b1;
          state_d  = dmc_pkg::ST_IDLE;
        end
      end
      default: state_d = dmc_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Totals and result
  // --------------------------------------------------------------------------
  assign is_read  = (func_q == dmc_pkg::FUNC_READ);
  assign cost     = hit_q ? hit_cost_q : miss_cost_q;
  assign time_sum = {1'b0, time_q} + {{(dmc_pkg::TOT_W + 1 - dmc_pkg::COST_W){1'b0}}, cost};

  always_comb begin
    reads_d  = reads_q;
    misses_d = misses_q;
    time_d   = time_q;
    if (is_read) begin
      reads_d = sat_inc(reads_q);
      time_d  = time_sum[dmc_pkg::TOT_W] ? '1 : time_sum[dmc_pkg::TOT_W-1:0];
      if (!hit_q) begin
        misses_d = sat_inc(misses_q);
      end
    end
  end

  always_comb begin
    rsp_d.rdata        = '0;
    if (is_read) begin
      rsp_d.rdata = hit_q ? lmem_rdata : miss_byte_q;
    end
    rsp_d.tag          = addr_tag;
    rsp_d.line_index   = addr_line;
    rsp_d.word_offset  = addr_word;
    rsp_d.block_number = addr_blk;
    rsp_d.time_total   = time_d;
    rsp_d.misses_total = misses_d;
    rsp_d.reads_total  = reads_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q      <= '0;
      misses_q    <= '0;
      reads_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rsp_load) begin
        time_q      <= time_d;
        misses_q    <= misses_d;
        reads_q     <= reads_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_q     <= rsp_d;
      out_hit_q <= hit_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = {{(dmc_pkg::RSP_W - dmc_pkg::RSP_USED_W){1'b0}}, rsp_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DMC_ASSERT_NEVER(a_fill_bound, clk_i, rst_ni,
    (state_q == dmc_pkg::ST_FILL && fill_cnt_q > dmc_pkg::FILL_DONE),
    "refill counter ran past the line")
  `DMC_ASSERT(a_refill_owns_line, clk_i, rst_ni,
    ((state_q == dmc_pkg::ST_FILL && fill_cnt_q == dmc_pkg::FILL_DONE) |=>
     (line_valid_q[addr_line] && line_tag_q[addr_line] == addr_tag)),
    "refilled line not valid or tag mismatch")
  `DMC_ASSERT_NEVER(a_misses_le_reads, clk_i, rst_ni,
    (out_valid_q && (rsp_q.misses_total > rsp_q.reads_total)),
    "more misses than reads reported")
  `DMC_ASSERT_NEVER(a_hit_no_fill, clk_i, rst_ni,
    (state_q == dmc_pkg::ST_FILL && hit_q),
    "refill running for a hit")

endmodule

### rtl/core/dmc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dmc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### test/direct_mapped_cache_read_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direct-mapped cache read: result checker
// Watches the request and result streams and the cost register writes. Keeps
// its own copy of backing RAM, line store, tags, valid bits, costs and the
// saturating totals, works out the result of every accepted request and
// compares each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module direct_mapped_cache_read_check #(
  parameter int unsigned RAM_BYTES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dmc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dmc_pkg::COST_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [dmc_pkg::REQ_W-1:0]       s_axis_tdata,  // addr, wdata
  input  logic                            s_axis_tuser,  // func
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // rdata, tag, line_index, word_offset, block_number, time_total,
  // misses_total, reads_total
  input  logic [dmc_pkg::RSP_W-1:0]       m_axis_tdata,
  input  logic                            m_axis_tuser,  // hit
  output int unsigned                     pending_o,
  output int unsigned                     fail_count_o
);
  import dmc_pkg::*;

  localparam logic [DATA_W-1:0] RESET_FILL = 8'h23;

  typedef struct packed {
    logic      hit;
    rsp_data_t data;
  } cache_reply_t;

  logic [DATA_W-1:0] ram_copy  [RAM_BYTES];
  logic [DATA_W-1:0] line_copy [NUM_LINES][LINE_BYTES];
  logic [TAG_W-1:0]  tag_copy  [NUM_LINES];
  logic              vld_copy  [NUM_LINES];
  logic [TOT_W-1:0]  time_acc;
  logic [TOT_W-1:0]  miss_acc;
  logic [TOT_W-1:0]  read_acc;
  logic [COST_W-1:0] hit_cost;
  logic [COST_W-1:0] miss_cost;
  cache_reply_t      lookup_replies [$];

  function automatic logic [TOT_W-1:0] sat_add(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b);
    logic [TOT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TOT_W] ? '1 : sum[TOT_W-1:0];
  endfunction

  function automatic cache_reply_t predict_access(func_e op, logic [ADDR_W-1:0] addr,
                                                  logic [DATA_W-1:0] wdata);
    cache_reply_t     r;
    logic [BLK_W-1:0] blk;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tg;
    logic [OFF_W-1:0] off;
    blk = addr[ADDR_W-1:OFF_W];
    off = addr[OFF_W-1:0];
    idx = blk[IDX_W-1:0];
    tg  = blk[BLK_W-1:IDX_W];
    r   = '0;
    if (op == FUNC_STORE) begin
      ram_copy[addr % RAM_BYTES] = wdata;
    end else begin
      read_acc = sat_add(read_acc, TOT_W'(1));
      if (vld_copy[idx] && tag_copy[idx] == tg) begin
        r.hit    = 1'b1;
        time_acc = sat_add(time_acc, TOT_W'(hit_cost));
      end else begin
        // refill the whole line, an invalid line misses whatever its tag
        for (int i = 0; i < LINE_BYTES; i++) begin
          line_copy[idx][i] = ram_copy[(blk * LINE_BYTES + i) % RAM_BYTES];
        end
        tag_copy[idx] = tg;
        vld_copy[idx] = 1'b1;
        miss_acc      = sat_add(miss_acc, TOT_W'(1));
        time_acc      = sat_add(time_acc, TOT_W'(miss_cost));
      end
      r.data.rdata = line_copy[idx][off];
    end
    r.data.tag          = tg;
    r.data.line_index   = idx;
    r.data.word_offset  = off;
    r.data.block_number = blk;
    r.data.time_total   = time_acc;
    r.data.misses_total = miss_acc;
    r.data.reads_total  = read_acc;
    return r;
  endfunction

  function automatic int unsigned field_diff(string name, logic [TOT_W-1:0] want,
                                             logic [TOT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t want;
    rsp_data_t    got;
    req_data_t    req;
    int unsigned  errs;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LINES; i++) begin
        for (int j = 0; j < LINE_BYTES; j++) line_copy[i][j] = RESET_FILL;
        tag_copy[i] = '0;
        vld_copy[i] = 1'b0;
      end
      time_acc  = '0;
      miss_acc  = '0;
      read_acc  = '0;
      hit_cost  = HIT_COST_RST;
      miss_cost = MISS_COST_RST;
      lookup_replies.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HIT_COST:  hit_cost  = cfg_wdata_i;
          CFG_MISS_COST: miss_cost = cfg_wdata_i;
          default: ;
        endcase
      end
      // results leave before the request of the same edge is predicted
      if (m_axis_tvalid && m_axis_tready) begin
        got = rsp_data_t'(m_axis_tdata[RSP_USED_W-1:0]);
        if (lookup_replies.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          errs++;
        end else begin
          want = lookup_replies.pop_front();
          errs += field_diff("rdata", want.data.rdata, got.rdata);
          errs += field_diff("hit", want.hit, m_axis_tuser);
          errs += field_diff("tag", want.data.tag, got.tag);
          errs += field_diff("line_index", want.data.line_index, got.line_index);
          errs += field_diff("word_offset", want.data.word_offset, got.word_offset);
          errs += field_diff("block_number", want.data.block_number, got.block_number);
          errs += field_diff("time_total", want.data.time_total, got.time_total);
          errs += field_diff("misses_total", want.data.misses_total, got.misses_total);
          errs += field_diff("reads_total", want.data.reads_total, got.reads_total);
          errs += field_diff("tdata padding", '0, TOT_W'(m_axis_tdata[RSP_W-1:RSP_USED_W]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req = req_data_t'(s_axis_tdata[REQ_USED_W-1:0]);
        lookup_replies.push_back(predict_access(func_e'(s_axis_tuser), req.addr, req.wdata));
      end
      pending_o    <= lookup_replies.size();
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

### test/direct_mapped_cache_read_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direct-mapped cache read: testbench top
// Drives byte stores and cache reads with random gaps on both streams, walks
// through several hit and miss cost settings and gives the verdict from the
// checker's failure count. Reads only touch blocks whose every byte has been
// stored, so refills never pick up unwritten backing RAM.
// ----------------------------------------------------------------------------
module direct_mapped_cache_read_test;
  import dmc_pkg::*;

  localparam int unsigned RAM_BYTES    = 4096;
  localparam int unsigned NUM_BLOCKS   = RAM_BYTES / LINE_BYTES;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 316;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned STALL_LIMIT  = 3000;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [COST_W-1:0]     cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [REQ_W-1:0]      s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [RSP_W-1:0]      m_axis_tdata;
  logic                  m_axis_tuser;

  int unsigned           pending;
  int unsigned           fail_count;
  int unsigned           idle_cycles   = 0;
  int unsigned           sent          = 0;
  logic                  hold_req      = 1'b0;
  logic                  steady        = 1'b0;
  logic                  stored_byte   [RAM_BYTES];
  logic                  block_ready   [NUM_BLOCKS];
  logic [BLK_W-1:0]      ready_blocks  [$];
  logic [BLK_W-1:0]      last_block    = '0;
  logic [TAG_W-1:0]      hot_tags      [4];

  always #5 clk_i = ~clk_i;

  direct_mapped_cache_read #(
    .RAM_BYTES(RAM_BYTES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  direct_mapped_cache_read_check #(
    .RAM_BYTES(RAM_BYTES)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken,
  // or after the gap that follows it.
  task automatic send_request(func_e op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
    req_data_t   req;
    int unsigned gap;
    req.addr  = addr;
    req.wdata = wdata;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= REQ_W'(req);
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
    gap = (steady || hold_req) ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic store_byte(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] wdata);
    logic [BLK_W-1:0] blk;
    logic             full;
    blk = addr[ADDR_W-1:OFF_W];
    send_request(FUNC_STORE, addr, wdata);
    stored_byte[addr] = 1'b1;
    full = 1'b1;
    for (int i = 0; i < LINE_BYTES; i++) full &= stored_byte[blk * LINE_BYTES + i];
    if (full && !block_ready[blk]) begin
      block_ready[blk] = 1'b1;
      ready_blocks.push_back(blk);
    end
  endtask

  task automatic fill_block(logic [BLK_W-1:0] blk);
    for (int i = 0; i < LINE_BYTES; i++) store_byte({blk, OFF_W'(i)}, DATA_W'($urandom));
  endtask

  // Drop valid, wait for every result, then let the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_costs(logic [COST_W-1:0] hit_cost, logic [COST_W-1:0] miss_cost);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_HIT_COST;
    cfg_wdata_i <= hit_cost;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_MISS_COST;
    cfg_wdata_i <= miss_cost;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      gap = steady ? 0 : idle_len();
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned      phase_end;
    int unsigned      r;
    int unsigned      n;
    logic [BLK_W-1:0] blk;
    for (int i = 0; i < RAM_BYTES; i++) stored_byte[i] = 1'b0;
    for (int i = 0; i < NUM_BLOCKS; i++) block_ready[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: block 0 filled, miss on an invalid line whose reset tag
    // matches, hits, store at the top address, stale data after a store
    store_byte(12'h000, 8'h00);
    store_byte(12'h001, 8'hFF);
    for (int i = 2; i < LINE_BYTES; i++) store_byte(ADDR_W'(i), DATA_W'($urandom));
    send_request(FUNC_READ, 12'h000, 8'hFF);
    send_request(FUNC_READ, 12'h00F, 8'h00);
    store_byte(12'hFFF, 8'hFF);
    send_request(FUNC_READ, 12'h001, 8'h00);
    store_byte(12'h000, 8'h5A);
    send_request(FUNC_READ, 12'h000, 8'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        drain();
        case (phase)
          1:       set_costs(8'd0, 8'd0);
          2:       set_costs(8'd255, 8'd255);
          3:       set_costs(8'd0, 8'd255);
          4:       set_costs(8'd255, 8'd0);
          default: set_costs(COST_W'($urandom), COST_W'($urandom));
        endcase
      end
      steady = (phase == 3);
      // hold the result side off while requests keep coming
      if (phase == 1) hold_req = 1'b1;
      hot_tags[0] = (phase == 0) ? '0 : TAG_W'($urandom);
      hot_tags[1] = (phase == 0) ? '1 : TAG_W'($urandom);
      hot_tags[2] = TAG_W'($urandom);
      hot_tags[3] = TAG_W'($urandom);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          if ($urandom_range(0, 3) == 0) blk = BLK_W'($urandom);
          else blk = {hot_tags[$urandom_range(0, 3)], IDX_W'($urandom)};
          fill_block(blk);
        end else if (r < 80) begin
          n = $urandom_range(1, 12);
          repeat (n) begin
            if ($urandom_range(0, 1) == 0) blk = last_block;
            else blk = ready_blocks[$urandom_range(0, ready_blocks.size() - 1)];
            send_request(FUNC_READ, {blk, OFF_W'($urandom)}, DATA_W'($urandom));
            last_block = blk;
          end
        end else if (r < 95) begin
          store_byte(ADDR_W'($urandom), DATA_W'($urandom));
        end else begin
          // broken fill: part of a block, never read until completed
          blk = BLK_W'($urandom);
          n = $urandom_range(1, LINE_BYTES - 1);
          repeat (n) store_byte({blk, OFF_W'($urandom)}, DATA_W'($urandom));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
